[rtl/gqr_pkg.sv]
// Shared types, constants and rounding helper for the Givens QR block.
// Used by gqr_cs_unit, givens_qr_decomposition_top and gqr_checker.
`default_nettype none
package gqr_pkg;
    localparam int IDX_W           = 3;
    localparam int ADDR_W          = 2 * IDX_W;
    localparam int DEPTH           = 1 << ADDR_W;
    localparam int DATA_W          = 32;
    localparam int THR_W           = 16;
    localparam int CS_W            = 18;
    localparam int PROD_W          = CS_W + DATA_W;
    localparam int SUM_W           = PROD_W + 1;
    localparam int DEF_MATRIX_SIZE = 8;
    localparam int TDATA_OUT_W     = 72;

    localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sd65536;

    // Round raw Q19.32 to Q16.16 (half up) and saturate to 32 bits
    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W:0]    t;
        logic signed [SUM_W-16:0] q;
        begin
            t = {v[SUM_W-1], v} + (SUM_W+1)'(32768);
            q = (SUM_W-15)'(t >>> 16);
            if (q > (SUM_W-15)'(64'sh7FFF_FFFF))
                round_sat = 32'sh7FFF_FFFF;
            else if (q < -(SUM_W-15)'(64'sh8000_0000))
                round_sat = 32'sh8000_0000;
            else
                round_sat = q[DATA_W-1:0];
        end
    endfunction
endpackage
`default_nettype wire

[rtl/gqr_cs_unit.sv]
// Rotation coefficient unit: h = isqrt(x^2 + y^2) in Q16.16, c = x/h and s = y/h in signed Q2.16.
// Digit-serial root (one result bit a cycle) and shared restoring divider; uses gqr_pkg.
`default_nettype none
module gqr_cs_unit
    import gqr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [DATA_W-1:0] x_in,
    input  wire logic signed [DATA_W-1:0] y_in,
    output logic                          done,
    output logic signed [CS_W-1:0]        c_out,
    output logic signed [CS_W-1:0]        s_out
);
    typedef enum logic [2:0] {
        CS_IDLE, CS_SQX, CS_SQY, CS_SUM, CS_ROOT, CS_DSET, CS_DIV
    } cs_state_t;

    cs_state_t                 state_reg;
    logic                      xneg_reg, yneg_reg, sel_s_reg;
    logic [DATA_W-1:0]         ax_reg, ay_reg;
    logic [2*DATA_W-1:0]       sqx_reg, sqy_reg, rad_reg;
    logic [DATA_W-1:0]         root_reg;
    logic [DATA_W+2:0]         rem_reg;
    logic [4:0]                cnt_reg;
    logic [DATA_W-1:0]         drem_reg;
    logic [CS_W-2:0]           dlow_reg;
    logic [CS_W-2:0]           quo_reg;

    logic [DATA_W+2:0]         rem_sh, trial;
    logic [DATA_W:0]           dt;
    logic [DATA_W-1:0]         mag;
    logic [48:0]               dvd;
    logic [CS_W-2:0]           quo_nx;
    logic signed [CS_W-1:0]    quo_sgn;

    // Root step, divider step and divider setup
    always_comb
    begin
        rem_sh  = {rem_reg[DATA_W:0], rad_reg[2*DATA_W-1 -: 2]};
        trial   = {1'b0, root_reg, 2'b01};
        dt      = {drem_reg, dlow_reg[CS_W-2]};
        mag     = sel_s_reg ? ay_reg : ax_reg;
        dvd     = {1'b0, mag, 16'b0} + {18'b0, root_reg[DATA_W-1:1]};
        quo_nx  = {quo_reg[CS_W-3:0], (dt >= {1'b0, root_reg})};
        quo_sgn = (sel_s_reg ? yneg_reg : xneg_reg) ? -$signed({1'b0, quo_nx})
                                                    : $signed({1'b0, quo_nx});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            done      <= 1'b0;
            sel_s_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                CS_IDLE:
                begin
                    if (start)
                    begin
                        xneg_reg  <= x_in[DATA_W-1];
                        yneg_reg  <= y_in[DATA_W-1];
                        ax_reg    <= x_in[DATA_W-1] ? DATA_W'(-x_in) : x_in;
                        ay_reg    <= y_in[DATA_W-1] ? DATA_W'(-y_in) : y_in;
                        state_reg <= CS_SQX;
                    end
                end
                CS_SQX:
                begin
                    sqx_reg   <= ax_reg * ax_reg;
                    state_reg <= CS_SQY;
                end
                CS_SQY:
                begin
                    sqy_reg   <= ay_reg * ay_reg;
                    state_reg <= CS_SUM;
                end
                CS_SUM:
                begin
                    rad_reg   <= sqx_reg + sqy_reg;
                    root_reg  <= '0;
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= CS_ROOT;
                end
                CS_ROOT:
                begin
                    // one root bit a cycle, two radicand bits in
                    if (rem_sh >= trial)
                    begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[DATA_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[DATA_W-2:0], 1'b0};
                    end
                    rad_reg <= {rad_reg[2*DATA_W-3:0], 2'b00};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        sel_s_reg <= 1'b0;
                        state_reg <= CS_DSET;
                    end
                end
                CS_DSET:
                begin
                    // quotient fits 17 bits, so the top of the dividend is below h
                    drem_reg  <= dvd[48:17];
                    dlow_reg  <= dvd[16:0];
                    quo_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= CS_DIV;
                end
                CS_DIV:
                begin
                    if (dt >= {1'b0, root_reg})
                        drem_reg <= DATA_W'(dt - {1'b0, root_reg});
                    else
                        drem_reg <= dt[DATA_W-1:0];
                    dlow_reg <= {dlow_reg[CS_W-3:0], 1'b0};
                    quo_reg  <= quo_nx;
                    cnt_reg  <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(CS_W-2))
                    begin
                        if (sel_s_reg)
                        begin
                            s_out     <= quo_sgn;
                            done      <= 1'b1;
                            state_reg <= CS_IDLE;
                        end
                        else
                        begin
                            c_out     <= quo_sgn;
                            sel_s_reg <= 1'b1;
                            state_reg <= CS_DSET;
                        end
                    end
                end
                default: state_reg <= CS_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/givens_qr_decomposition_top.sv]
// Top level of the Givens-rotation QR block: R and Q memories and the sequencer.
// Depends on gqr_pkg and gqr_cs_unit.
//
// Usage: the slave stream takes matrix elements (signed Q16.16) in row-major
// order, one word a cycle while s_axis_tready is high. The word that completes
// the N x N matrix starts the decomposition; s_axis_tready stays low until the
// last result word has been taken.
// Work after the last element: Q is loaded with identity, then each
// below-diagonal position is tested against skip_threshold and, if rotated,
// c and s are computed and the two R rows and Q columns are updated element by
// element (read, multiply, write back). The root and divider in gqr_cs_unit and
// the single write port of each memory set the pace of this work.
// The master stream then gives N*N words in row-major order, each read from the
// memories and registered before the next read is issued; tlast marks the
// final one. A low tready holds the word and pauses the sweep.
// cfg_we writes skip_threshold; write only while idle.
// Reset (rst_n, asynchronous) clears the load position, threshold and control;
// memory contents are not cleared.
`default_nettype none
module givens_qr_decomposition_top
    import gqr_pkg::*;
#(
    parameter int MATRIX_SIZE = DEF_MATRIX_SIZE
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [THR_W-1:0]       cfg_wdata,      // skip_threshold
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [DATA_W-1:0]      s_axis_tdata,   // a_value
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0]      m_axis_tdata,   // row_index, col_index, q_value, r_value
    output logic                        m_axis_tlast    // last_result
);
    localparam logic [IDX_W-1:0] LAST  = IDX_W'(MATRIX_SIZE - 1);
    localparam logic [IDX_W-1:0] LAST2 = IDX_W'(MATRIX_SIZE - 2);

    typedef enum logic [3:0] {
        ST_LOAD, ST_QINIT, ST_PRD, ST_PCHK, ST_CS, ST_RRD, ST_RMUL, ST_RWA, ST_RWB, ST_EMIT
    } state_t;

    state_t                    state_reg;
    logic [THR_W-1:0]          thr_reg;
    logic [IDX_W-1:0]          row_reg, col_reg;
    logic [IDX_W-1:0]          j_reg, i_reg, k_reg;
    logic                      rot_q_reg;
    logic                      issued_all_reg, rd_pend_reg, pend_last_reg;
    logic [IDX_W-1:0]          pend_row_reg, pend_col_reg;
    logic                      cs_start_reg;
    logic signed [PROD_W-1:0]  pa_reg, pb_reg, pc_reg, pd_reg;
    logic                      m_valid_reg, m_last_reg;
    logic [IDX_W-1:0]          m_row_reg, m_col_reg;
    logic [DATA_W-1:0]         m_q_reg, m_r_reg;

    // memories
    logic [DATA_W-1:0]         r_mem [DEPTH];
    logic [DATA_W-1:0]         q_mem [DEPTH];
    logic [DATA_W-1:0]         r_rda_reg, r_rdb_reg, q_rda_reg, q_rdb_reg;
    logic                      r_we, q_we;
    logic [ADDR_W-1:0]         r_wa, q_wa, raa, rab;
    logic [DATA_W-1:0]         r_wd, q_wd;

    logic                      cs_done;
    logic signed [CS_W-1:0]    c_val, s_val;
    logic signed [DATA_W-1:0]  op_a, op_b;
    logic [DATA_W:0]           ay;
    logic                      in_acc, issue, out_take;
    logic [ADDR_W-1:0]         addr_a, addr_b;
    logic signed [DATA_W-1:0]  res_a, res_b;

    gqr_cs_unit u_cs (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cs_start_reg),
        .x_in  ($signed(r_rda_reg)),
        .y_in  ($signed(r_rdb_reg)),
        .done  (cs_done),
        .c_out (c_val),
        .s_out (s_val)
    );

    // Addresses, operands and write ports
    always_comb
    begin
        in_acc   = s_axis_tvalid && s_axis_tready;
        out_take = m_valid_reg && m_axis_tready;
        issue    = (state_reg == ST_EMIT) && !issued_all_reg && !rd_pend_reg
                   && (!m_valid_reg || m_axis_tready);
        ay       = r_rdb_reg[DATA_W-1] ? (DATA_W+1)'(-$signed({1'b1, r_rdb_reg}))
                                       : {1'b0, r_rdb_reg};
        addr_a   = rot_q_reg ? {k_reg, j_reg} : {j_reg, k_reg};
        addr_b   = rot_q_reg ? {k_reg, i_reg} : {i_reg, k_reg};
        op_a     = $signed(rot_q_reg ? q_rda_reg : r_rda_reg);
        op_b     = $signed(rot_q_reg ? q_rdb_reg : r_rdb_reg);
        res_a    = round_sat(SUM_W'(pa_reg) + SUM_W'(pb_reg));
        res_b    = round_sat(SUM_W'(pc_reg) - SUM_W'(pd_reg));

        raa = {j_reg, j_reg};
        rab = {i_reg, j_reg};
        case (state_reg)
            ST_RRD:  begin raa = addr_a; rab = addr_b; end
            ST_EMIT: begin raa = {row_reg, col_reg}; rab = {row_reg, col_reg}; end
            default: ;
        endcase

        r_we = 1'b0;
        r_wa = addr_a;
        r_wd = res_a;
        q_we = 1'b0;
        q_wa = addr_a;
        q_wd = res_a;
        case (state_reg)
            ST_LOAD:
            begin
                r_we = in_acc;
                r_wa = {row_reg, col_reg};
                r_wd = s_axis_tdata;
            end
            ST_QINIT:
            begin
                q_we = 1'b1;
                q_wa = {row_reg, col_reg};
                q_wd = (row_reg == col_reg) ? ONE_Q16 : '0;
            end
            ST_RWA:
            begin
                r_we = !rot_q_reg;
                q_we = rot_q_reg;
            end
            ST_RWB:
            begin
                r_we = !rot_q_reg;
                q_we = rot_q_reg;
                r_wa = addr_b;
                q_wa = addr_b;
                r_wd = res_b;
                q_wd = res_b;
            end
            default: ;
        endcase
    end

    // R memory: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (r_we)
            r_mem[r_wa] <= r_wd;
        r_rda_reg <= r_mem[raa];
        r_rdb_reg <= r_mem[rab];
    end

    // Q memory: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[q_wa] <= q_wd;
        q_rda_reg <= q_mem[raa];
        q_rdb_reg <= q_mem[rab];
    end

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= '0;
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            row_reg        <= '0;
            col_reg        <= '0;
            j_reg          <= '0;
            i_reg          <= '0;
            k_reg          <= '0;
            rot_q_reg      <= 1'b0;
            issued_all_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
            cs_start_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_last_reg     <= 1'b0;
        end
        else
        begin
            cs_start_reg <= 1'b0;
            case (state_reg)
                ST_LOAD:
                begin
                    if (in_acc)
                    begin
                        col_reg <= (col_reg == LAST) ? '0 : col_reg + 1'b1;
                        if (col_reg == LAST)
                        begin
                            row_reg <= (row_reg == LAST) ? '0 : row_reg + 1'b1;
                            if (row_reg == LAST)
                                state_reg <= ST_QINIT;
                        end
                    end
                end
                ST_QINIT:
                begin
                    col_reg <= (col_reg == LAST) ? '0 : col_reg + 1'b1;
                    if (col_reg == LAST)
                    begin
                        row_reg <= (row_reg == LAST) ? '0 : row_reg + 1'b1;
                        if (row_reg == LAST)
                        begin
                            j_reg     <= '0;
                            i_reg     <= IDX_W'(1);
                            state_reg <= ST_PRD;
                        end
                    end
                end
                ST_PRD: state_reg <= ST_PCHK;
                ST_PCHK:
                begin
                    if (ay <= {{(DATA_W+1-THR_W){1'b0}}, thr_reg})
                    begin
                        // skip: advance to the next position below the diagonal
                        if (i_reg == LAST)
                        begin
                            if (j_reg == LAST2)
                            begin
                                issued_all_reg <= 1'b0;
                                row_reg        <= '0;
                                col_reg        <= '0;
                                state_reg      <= ST_EMIT;
                            end
                            else
                            begin
                                j_reg     <= j_reg + 1'b1;
                                i_reg     <= j_reg + IDX_W'(2);
                                state_reg <= ST_PRD;
                            end
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= ST_PRD;
                        end
                    end
                    else
                    begin
                        cs_start_reg <= 1'b1;
                        state_reg    <= ST_CS;
                    end
                end
                ST_CS:
                begin
                    if (cs_done)
                    begin
                        k_reg     <= j_reg;
                        rot_q_reg <= 1'b0;
                        state_reg <= ST_RRD;
                    end
                end
                ST_RRD: state_reg <= ST_RMUL;
                ST_RMUL:
                begin
                    pa_reg    <= c_val * op_a;
                    pb_reg    <= s_val * op_b;
                    pc_reg    <= c_val * op_b;
                    pd_reg    <= s_val * op_a;
                    state_reg <= ST_RWA;
                end
                ST_RWA: state_reg <= ST_RWB;
                ST_RWB:
                begin
                    if (k_reg != LAST)
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_RRD;
                    end
                    else if (!rot_q_reg)
                    begin
                        rot_q_reg <= 1'b1;
                        k_reg     <= '0;
                        state_reg <= ST_RRD;
                    end
                    else if (i_reg == LAST)
                    begin
                        rot_q_reg <= 1'b0;
                        if (j_reg == LAST2)
                        begin
                            issued_all_reg <= 1'b0;
                            row_reg        <= '0;
                            col_reg        <= '0;
                            state_reg      <= ST_EMIT;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            i_reg     <= j_reg + IDX_W'(2);
                            state_reg <= ST_PRD;
                        end
                    end
                    else
                    begin
                        rot_q_reg <= 1'b0;
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_PRD;
                    end
                end
                ST_EMIT:
                begin
                    if (issue)
                    begin
                        pend_row_reg  <= row_reg;
                        pend_col_reg  <= col_reg;
                        pend_last_reg <= (row_reg == LAST) && (col_reg == LAST);
                        col_reg <= (col_reg == LAST) ? '0 : col_reg + 1'b1;
                        if (col_reg == LAST)
                        begin
                            row_reg <= (row_reg == LAST) ? '0 : row_reg + 1'b1;
                            if (row_reg == LAST)
                                issued_all_reg <= 1'b1;
                        end
                    end
                    if (out_take && m_last_reg)
                        state_reg <= ST_LOAD;
                end
                default: state_reg <= ST_LOAD;
            endcase

            // output register: load read data, drop when taken
            rd_pend_reg <= issue;
            if (rd_pend_reg)
            begin
                m_valid_reg <= 1'b1;
                m_row_reg   <= pend_row_reg;
                m_col_reg   <= pend_col_reg;
                m_last_reg  <= pend_last_reg;
                m_q_reg     <= q_rda_reg;
                m_r_reg     <= r_rda_reg;
            end
            else if (out_take)
            begin
                m_valid_reg <= 1'b0;
                m_last_reg  <= 1'b0;
            end
        end
    end

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {2'b00, m_r_reg, m_q_reg, m_col_reg, m_row_reg};
endmodule
`default_nettype wire

[rtl/gqr_checker.sv]
// Port-level assertions for givens_qr_decomposition_top, bound to the top level.
// Depends on gqr_pkg.
`default_nettype none
module gqr_checker
    import gqr_pkg::*;
#(
    parameter int MATRIX_SIZE = DEF_MATRIX_SIZE
)
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [TDATA_OUT_W-1:0] m_axis_tdata,
    input wire logic                   m_axis_tlast
);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(MATRIX_SIZE - 1);

    // no input taken while results are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    // final word is the bottom-right position
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata[IDX_W-1:0] == LAST && m_axis_tdata[2*IDX_W-1:IDX_W] == LAST)
        else $error("last word not at final position");

    // load reopens once the final word is taken
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
        else $error("input not reopened after last result");
endmodule

bind givens_qr_decomposition_top gqr_checker #(.MATRIX_SIZE(MATRIX_SIZE)) u_gqr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
